>>> rtl/pbr_pkg.sv
// Shared types, constants and pixel packing helpers for the packed pixel bitmap RAM.
package pbr_pkg;

  localparam int ADDR_W  = 20;  // pixel address width
  localparam int PIX_W   = 4;   // pixel field width
  localparam int BYTE_W  = 8;   // backing RAM word width
  localparam int SHIFT_W = 19;  // pixel address after the smallest shift
  localparam int CNT_W   = 2;   // index unit step count

  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0f;
  localparam logic [BYTE_W-1:0] PAIR_MASK   = 8'h03;

  // Request from the control logic to the byte index unit.
  typedef struct packed {
    logic start;
    logic two_bit;
  } pbr_idx_req_t;

  function automatic logic [2:0] pbr_pos(input logic two_bit, input logic [1:0] sub);
    return two_bit ? {sub, 1'b0} : {sub[0], 2'b00};
  endfunction

  function automatic logic [BYTE_W-1:0] pbr_mask(input logic two_bit);
    return two_bit ? PAIR_MASK : NIBBLE_MASK;
  endfunction

  function automatic logic [PIX_W-1:0] pbr_extract(input logic [BYTE_W-1:0] b,
                                                  input logic two_bit,
                                                  input logic [1:0] sub);
    logic [BYTE_W-1:0] f;
    f = (b >> pbr_pos(two_bit, sub)) & pbr_mask(two_bit);
    return f[PIX_W-1:0];
  endfunction

  function automatic logic [BYTE_W-1:0] pbr_merge(input logic [BYTE_W-1:0] b,
                                                 input logic two_bit,
                                                 input logic [1:0] sub,
                                                 input logic [PIX_W-1:0] val);
    logic [2:0] pos;
    logic [BYTE_W-1:0] mask;
    pos  = pbr_pos(two_bit, sub);
    mask = pbr_mask(two_bit);
    return (b & ~(mask << pos)) | (({4'b0, val} & mask) << pos);
  endfunction

endpackage

>>> rtl/pbr_ram.sv
// Byte-wide single-port-write, single-port-read RAM with registered read data.
module pbr_ram #(
  parameter int DEPTH  = 131072,
  parameter int ADDR_W = 17
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/pbr_index.sv
// Byte index unit: pixel address shifted by mode and wrapped to the RAM size.
module pbr_index
  import pbr_pkg::*;
#(
  parameter int RAM_BYTES = 131072,
  parameter int IDX_W     = 17
) (
  input  logic               clk,
  input  logic               rst,
  input  pbr_idx_req_t       req,
  input  logic [ADDR_W-1:0]  pixel_address,
  output logic [IDX_W-1:0]   idx,
  output logic               idx_done
);

  localparam bit IS_POW2 = (RAM_BYTES & (RAM_BYTES - 1)) == 0;

  logic [SHIFT_W-1:0] shifted;

  assign shifted = req.two_bit ? {1'b0, pixel_address[ADDR_W-1:2]}
                               : pixel_address[ADDR_W-1:1];

  if (IS_POW2) begin : g_mask
    // wrap is a plain mask, index ready in the request cycle
    assign idx      = shifted[IDX_W-1:0];
    assign idx_done = req.start;
  end else begin : g_recip
    // reciprocal multiply: quotient estimate (low by at most one),
    // remainder, then one correcting subtract; three steps
    localparam int               Q_W       = SHIFT_W + 1 - IDX_W;
    localparam int               PROD_W    = SHIFT_W + Q_W;
    localparam logic [Q_W-1:0]   RECIP     = Q_W'((1 << SHIFT_W) / RAM_BYTES);
    localparam logic [IDX_W:0]   DIVISOR   = (IDX_W+1)'(RAM_BYTES);
    localparam logic [CNT_W-1:0] STEP_QUO  = CNT_W'(0);
    localparam logic [CNT_W-1:0] STEP_REM  = CNT_W'(1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(2);

    logic               busy;
    logic [CNT_W-1:0]   step;
    logic [SHIFT_W-1:0] vsh;
    logic [Q_W-1:0]     quo;
    logic [IDX_W:0]     rem;
    logic [PROD_W-1:0]  prod;
    logic [SHIFT_W-1:0] back;
    logic [SHIFT_W-1:0] diff;

    assign prod = PROD_W'(vsh) * PROD_W'(RECIP);
    assign back = SHIFT_W'(quo) * SHIFT_W'(RAM_BYTES);
    assign diff = vsh - back;

    always_ff @(posedge clk) begin
      if (rst) begin
        busy <= 1'b0;
        step <= '0;
      end else if (req.start) begin
        busy <= 1'b1;
        step <= '0;
        vsh  <= shifted;
      end else if (busy) begin
        if (step == LAST_STEP) begin
          busy <= 1'b0;
        end else begin
          step <= step + CNT_W'(1);
        end
        if (step == STEP_QUO) begin
          quo <= prod[PROD_W-1:SHIFT_W];
        end
        if (step == STEP_REM) begin
          rem <= diff[IDX_W:0];
        end
      end
    end

    // remainder estimate is below twice the RAM size
    assign idx      = (rem >= DIVISOR) ? IDX_W'(rem - DIVISOR) : rem[IDX_W-1:0];
    assign idx_done = busy && (step == LAST_STEP);
  end

endmodule

>>> rtl/packed_pixel_bitmap_ram.sv
// Top level: pixel-addressed read and read-modify-write access to a byte RAM.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  in       | in_valid / in_stall  | action, pixel_address, pixel_value
//  out      | out_valid / out_stall| read_pixel (read actions only)
//  cfg      | cfg_valid / cfg_ready| two_bit_mode (always ready)
//
//  One item at a time. With a power-of-two RAM_BYTES an item is accepted
//  and its RAM read issued in ST_IDLE, then merged and written back, or its
//  result loaded, in ST_MERGE. Otherwise the byte index wrap adds three
//  reciprocal-multiply steps in ST_REDUCE, the RAM read on the last.
//  After reset the RAM is swept to zero, one byte per cycle over all
//  RAM_BYTES bytes, with in_stall high. A read whose result finds out held by
//  out_stall waits in the merge stage; the output register still drains.
module packed_pixel_bitmap_ram
  import pbr_pkg::*;
#(
  parameter int RAM_BYTES = 131072
) (
  input  logic              clk,
  input  logic              rst,
  // item input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              action,
  input  logic [ADDR_W-1:0] pixel_address,
  input  logic [PIX_W-1:0]  pixel_value,
  // result output
  output logic              out_valid,
  input  logic              out_stall,
  output logic [PIX_W-1:0]  read_pixel,
  // configuration write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              two_bit_mode
);

  localparam int IDX_W = $clog2(RAM_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RAM_BYTES - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_MERGE
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  clr_addr;
  logic              two_bit_sel;   // mode register

  // captured item
  logic              act_q;
  logic [1:0]        sub_q;
  logic [PIX_W-1:0]  val_q;
  logic              mode_q;
  logic [IDX_W-1:0]  idx_q;

  pbr_idx_req_t      idx_req;
  logic [IDX_W-1:0]  idx;
  logic              idx_done;

  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic [BYTE_W-1:0] rd_data;

  logic              res_load;      // read result moves into the output register

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);

  assign idx_req.start   = (state == ST_IDLE) && in_valid;
  assign idx_req.two_bit = two_bit_sel;

  assign res_load = (state == ST_MERGE) && (act_q == ACT_READ) && (!out_valid || !out_stall);

  pbr_index #(
    .RAM_BYTES (RAM_BYTES),
    .IDX_W     (IDX_W)
  ) u_index (
    .clk           (clk),
    .rst           (rst),
    .req           (idx_req),
    .pixel_address (pixel_address),
    .idx           (idx),
    .idx_done      (idx_done)
  );

  // write port: clearing sweep, or write-back of the merged byte
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = pbr_merge(rd_data, mode_q, sub_q, val_q);
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (state == ST_MERGE && act_q == ACT_WRITE) begin
      wr_en = 1'b1;
    end
  end

  // RAM read issued as soon as the byte index is known
  pbr_ram #(
    .DEPTH  (RAM_BYTES),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (idx_done),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      two_bit_sel <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        two_bit_sel <= two_bit_mode;
      end
      if (res_load) begin
        out_valid  <= 1'b1;
        read_pixel <= pbr_extract(rd_data, mode_q, sub_q);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == LAST_IDX) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + IDX_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            act_q  <= action;
            sub_q  <= pixel_address[1:0];
            val_q  <= pixel_value;
            mode_q <= two_bit_sel;
            if (idx_done) begin
              idx_q <= idx;
              state <= ST_MERGE;
            end else begin
              state <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (idx_done) begin
            idx_q <= idx;
            state <= ST_MERGE;
          end
        end
        ST_MERGE: begin
          // write-back completes here, so the next read sees it
          if (act_q == ACT_WRITE || res_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/pbr_checker.sv
// Port-level checks for the packed pixel bitmap RAM, bound to the top level.
module pbr_checker
  import pbr_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_stall,
  input logic             action,
  input logic             out_valid,
  input logic             out_stall,
  input logic [PIX_W-1:0] read_pixel
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_pixel))
    else $error("result changed while stalled");

  // RAM clearing sweep blocks input right after reset
  a_clear_stall: assert property (@(posedge clk)
    $fell(rst) |-> in_stall)
    else $error("input taken during clearing sweep");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while busy");

  // a write never brings a result
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && action == ACT_WRITE |=> !$rose(out_valid))
    else $error("result produced for a write");

endmodule

bind packed_pixel_bitmap_ram pbr_checker u_pbr_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .action     (action),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .read_pixel (read_pixel)
);

>>> test/packed_pixel_bitmap_ram_test.sv
// Self-checking testbench for the packed pixel bitmap RAM: directed table, then random traffic.
`timescale 1ns / 100ps

module packed_pixel_bitmap_ram_test
  import pbr_pkg::*;
();

  localparam int RAM_BYTES      = 131072;
  // the block sweeps its RAM after reset, so the quiet-cycle limit must cover that pass
  localparam int WATCHDOG_LIMIT = 3 * RAM_BYTES + 4096;
  // a write gives no result; let it finish before the mode changes
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_ITEMS   = 1930;
  localparam int MODE_PERIOD    = 160;   // random items between mode changes
  localparam int LONG_HOLD      = 300;   // receiver hold-off, in cycles
  localparam int MAX_REPORTS    = 10;

  localparam logic MODE_4BPP = 1'b0;
  localparam logic MODE_2BPP = 1'b1;

  // One directed stimulus row. "typed" marks rows whose result is written out here;
  // every other read is checked against the predictor.
  typedef struct packed {
    logic              mode;
    logic              act;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  val;
    logic              typed;
    logic [PIX_W-1:0]  want;
  } access_row_t;

  localparam int DIRECTED_ROWS = 23;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              action;
  logic [ADDR_W-1:0] pixel_address;
  logic [PIX_W-1:0]  pixel_value;
  logic              out_valid;
  logic              out_stall;
  logic [PIX_W-1:0]  read_pixel;
  logic              cfg_valid;
  logic              cfg_ready;
  logic              two_bit_mode;

  // Predictor state: its own copy of the byte RAM and of the mode register.
  logic [BYTE_W-1:0] shadow_bytes [RAM_BYTES];
  logic              shadow_two_bit;
  logic [PIX_W-1:0]  pending_pixels [$];   // read results still owed by the block

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_hold_len;    // set by the stimulus, taken by the receiver
  int unsigned hold_left;
  int unsigned idle_cycles;
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned reads_checked;
  int unsigned mode_writes;
  logic [PIX_W-1:0] want_pixel;

  access_row_t directed_rows [DIRECTED_ROWS];

  packed_pixel_bitmap_ram #(
    .RAM_BYTES(RAM_BYTES)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .pixel_address(pixel_address),
    .pixel_value  (pixel_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .read_pixel   (read_pixel),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .two_bit_mode (two_bit_mode)
  );

  always #2 clk = ~clk;

  // Predictor: one pixel access against the shadow RAM under the current mode.
  // 4bpp: two nibbles per byte, low first. 2bpp: four pairs per byte, low first.
  // The byte index wraps modulo the RAM size.
  task automatic apply_pixel_access(input logic act, input logic [ADDR_W-1:0] addr,
                                    input logic [PIX_W-1:0] val,
                                    output logic [PIX_W-1:0] pix);
    int unsigned       idx;
    int unsigned       pos;
    logic [BYTE_W-1:0] fmask;
    logic [BYTE_W-1:0] cur;
    logic [BYTE_W-1:0] field;
    if (shadow_two_bit) begin
      pos   = int'(addr[1:0]) * 2;
      fmask = 8'h03;
      idx   = (int'(addr) >> 2) % RAM_BYTES;
    end else begin
      pos   = int'(addr[0]) * 4;
      fmask = 8'h0f;
      idx   = (int'(addr) >> 1) % RAM_BYTES;
    end
    cur   = shadow_bytes[idx];
    field = (cur >> pos) & fmask;
    pix   = field[PIX_W-1:0];
    if (act == ACT_WRITE)
      shadow_bytes[idx] = (cur & ~(fmask << pos)) | (({4'b0, val} & fmask) << pos);
  endtask

  // Offer one item, honoring the sender idle rate; predict at the accepting edge.
  task automatic send_item(input logic act, input logic [ADDR_W-1:0] addr,
                           input logic [PIX_W-1:0] val, input logic typed = 1'b0,
                           input logic [PIX_W-1:0] want = '0);
    logic [PIX_W-1:0] pix;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    pixel_address <= addr;
    pixel_value   <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_pixel_access(act, addr, val, pix);
    if (act == ACT_READ)
      pending_pixels.push_back(typed ? want : pix);
    items_sent++;
  endtask

  // Stop offering, wait for every owed result, then let in-flight writes land.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid    <= 1'b1;
    two_bit_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid      <= 1'b0;
    shadow_two_bit = m;
    mode_writes++;
  endtask

  // Addresses near the two ends of the RAM or anywhere in it, aliased through the upper
  // address bits so the wrap gets exercised; a quarter are fully random.
  function automatic logic [ADDR_W-1:0] pick_address(input logic two_bit);
    int unsigned idx;
    int unsigned shift;
    logic [31:0] a;
    shift = two_bit ? 2 : 1;
    case ($urandom_range(0, 3))
      0: idx = $urandom_range(0, 15);
      1: idx = RAM_BYTES - 1 - $urandom_range(0, 15);
      default: idx = $urandom_range(0, RAM_BYTES - 1);
    endcase
    a = ((idx + $urandom_range(0, 3) * RAM_BYTES) << shift) |
        $urandom_range(0, (1 << shift) - 1);
    if ($urandom_range(0, 3) == 0)
      a = $urandom;
    return a[ADDR_W-1:0];
  endfunction

  // Random traffic: mostly write/read-back sequences on one byte, plus loose noise.
  task automatic run_random_phase(input int unsigned count);
    int unsigned       stop_at;
    int unsigned       next_mode_at;
    int unsigned       kind;
    int unsigned       npix;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] base;
    stop_at      = items_sent + count;
    next_mode_at = items_sent + MODE_PERIOD;
    while (items_sent < stop_at) begin
      if (items_sent >= next_mode_at) begin
        wait_drained();
        write_mode(~shadow_two_bit);
        next_mode_at = items_sent + MODE_PERIOD;
      end
      kind = $urandom_range(0, 9);
      a    = pick_address(shadow_two_bit);
      if (kind <= 3) begin
        // write, a little traffic in between, read back
        send_item(ACT_WRITE, a, PIX_W'($urandom_range(0, 15)));
        repeat ($urandom_range(0, 2))
          send_item(logic'($urandom_range(0, 1)), pick_address(shadow_two_bit),
                    PIX_W'($urandom_range(0, 15)));
        send_item(ACT_READ, a, PIX_W'($urandom_range(0, 15)));
      end else if (kind <= 5) begin
        // back-to-back writes to every pixel of one byte, then read them all
        npix = shadow_two_bit ? 4 : 2;
        base = a & ~ADDR_W'(npix - 1);
        for (int j = 0; j < npix; j++)
          send_item(ACT_WRITE, base | ADDR_W'(j), PIX_W'($urandom_range(0, 15)));
        for (int j = 0; j < npix; j++)
          send_item(ACT_READ, base | ADDR_W'(j), PIX_W'($urandom_range(0, 15)));
      end else if (kind == 6) begin
        send_item(ACT_READ, a, PIX_W'($urandom_range(0, 15)));
        send_item(ACT_WRITE, a, PIX_W'($urandom_range(0, 15)));
        send_item(ACT_READ, a, PIX_W'($urandom_range(0, 15)));
      end else begin
        send_item(logic'($urandom_range(0, 1)), a, PIX_W'($urandom_range(0, 15)));
      end
    end
  endtask

  // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_hold_len != 0) begin
        hold_left      = stall_hold_len;
        stall_hold_len = 0;
        out_stall <= 1'b1;
        repeat (hold_left) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Result check: each transfer on the output against the oldest owed pixel.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result transfer: read_pixel=%h", read_pixel);
      end else begin
        want_pixel = pending_pixels.pop_front();
        reads_checked++;
        if (read_pixel !== want_pixel) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("read_pixel mismatch: expected %h, got %h", want_pixel, read_pixel);
        end
      end
    end
  end

  // Watchdog: counts cycles in which no channel completes a transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results owed",
               idle_cycles, pending_pixels.size());
      $display("FAIL packed_pixel_bitmap_ram");
      $finish;
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    action         = ACT_READ;
    pixel_address  = '0;
    pixel_value    = '0;
    cfg_valid      = 1'b0;
    two_bit_mode   = MODE_4BPP;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    stall_hold_len = 0;
    idle_cycles    = 0;
    fail_count     = 0;
    items_sent     = 0;
    reads_checked  = 0;
    mode_writes    = 0;
    shadow_two_bit = MODE_4BPP;
    foreach (shadow_bytes[i]) shadow_bytes[i] = '0;

    // Directed rows. Typed results: cleared RAM after reset, nibble write-back,
    // the address wrap in both directions. Mode switches read bytes written
    // under the other packing, and a 2bpp write carries unused value bits.
    directed_rows = '{
      '{MODE_4BPP, ACT_READ,  20'h00000, 4'h0, 1'b1, 4'h0},  // cleared after reset
      '{MODE_4BPP, ACT_READ,  20'hfffff, 4'h0, 1'b1, 4'h0},  // top address, cleared
      '{MODE_4BPP, ACT_WRITE, 20'h00000, 4'hf, 1'b0, 4'h0},
      '{MODE_4BPP, ACT_WRITE, 20'h00001, 4'ha, 1'b0, 4'h0},  // same byte, back to back
      '{MODE_4BPP, ACT_READ,  20'h00000, 4'h0, 1'b1, 4'hf},
      '{MODE_4BPP, ACT_READ,  20'h00001, 4'h0, 1'b1, 4'ha},
      '{MODE_4BPP, ACT_READ,  20'h40000, 4'h0, 1'b1, 4'hf},  // wraps onto byte 0
      '{MODE_4BPP, ACT_WRITE, 20'hfffff, 4'h5, 1'b0, 4'h0},  // wraps onto last byte
      '{MODE_4BPP, ACT_READ,  20'h3ffff, 4'h0, 1'b1, 4'h5},
      '{MODE_4BPP, ACT_WRITE, 20'h3fffe, 4'hc, 1'b0, 4'h0},
      '{MODE_4BPP, ACT_READ,  20'hffffe, 4'h0, 1'b1, 4'hc},
      '{MODE_2BPP, ACT_READ,  20'h00000, 4'h0, 1'b0, 4'h0},
      '{MODE_2BPP, ACT_READ,  20'h00003, 4'h0, 1'b0, 4'h0},
      '{MODE_2BPP, ACT_WRITE, 20'h00002, 4'hd, 1'b0, 4'h0},  // upper value bits unused
      '{MODE_2BPP, ACT_READ,  20'h00002, 4'hf, 1'b0, 4'h0},
      '{MODE_2BPP, ACT_READ,  20'h80002, 4'h0, 1'b0, 4'h0},  // alias of pixel 2
      '{MODE_2BPP, ACT_WRITE, 20'hfffff, 4'h2, 1'b0, 4'h0},
      '{MODE_2BPP, ACT_READ,  20'h7ffff, 4'h0, 1'b0, 4'h0},
      '{MODE_2BPP, ACT_READ,  20'hffffc, 4'h0, 1'b0, 4'h0},
      '{MODE_2BPP, ACT_WRITE, 20'h00001, 4'h0, 1'b0, 4'h0},
      '{MODE_2BPP, ACT_READ,  20'h00001, 4'h0, 1'b0, 4'h0},
      '{MODE_4BPP, ACT_READ,  20'h00000, 4'h0, 1'b0, 4'h0},  // back to 4bpp
      '{MODE_4BPP, ACT_READ,  20'h00001, 4'h0, 1'b0, 4'h0}
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_mode(MODE_4BPP);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].mode != shadow_two_bit) begin
        wait_drained();
        write_mode(directed_rows[r].mode);
      end
      send_item(directed_rows[r].act, directed_rows[r].addr, directed_rows[r].val,
                directed_rows[r].typed, directed_rows[r].want);
    end
    wait_drained();

    // Phase 1: sender idles lightly, receiver heavily. It opens with a long
    // receiver hold-off while reads keep coming, so the block backs up and
    // stalls its input; then the sender waits for everything to drain.
    send_idle_pct  = 20;
    recv_idle_pct  = 53;
    stall_hold_len = LONG_HOLD;
    for (int j = 0; j < 16; j++)
      send_item(ACT_READ, pick_address(shadow_two_bit), PIX_W'($urandom_range(0, 15)));
    wait_drained();
    run_random_phase(RANDOM_ITEMS / 3 - 16);

    // Phase 2: the other way round.
    send_idle_pct = 53;
    recv_idle_pct = 20;
    run_random_phase(RANDOM_ITEMS / 3);

    // Phase 3: full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    wait_drained();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d pixel accesses, %0d read results checked, %0d mode writes",
             items_sent, reads_checked, mode_writes);
    $display("both packings, address wrap, same-byte write bursts, long output hold-off");
    if (fail_count == 0)
      $display("PASS packed_pixel_bitmap_ram");
    else
      $display("FAIL packed_pixel_bitmap_ram");
    $finish;
  end

endmodule

>>> files.f
rtl/pbr_pkg.sv
rtl/pbr_ram.sv
rtl/pbr_index.sv
rtl/packed_pixel_bitmap_ram.sv
rtl/pbr_checker.sv
test/packed_pixel_bitmap_ram_test.sv
